// ===== rtl/key_state_double_press_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Key state double press tracker assertion macros
// Shared concurrent assertion forms for the tracker checker.
// ----------------------------------------------------------------------------
`ifndef KEY_STATE_DOUBLE_PRESS_TRACKER_CORE_DEFINES_SVH
`define KEY_STATE_DOUBLE_PRESS_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define KSDPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ksdpt assertion failed");

// Implication checked at a later clock than the antecedent, disabled while in reset.
`define KSDPT_ASSERT_LAT2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("ksdpt assertion failed");

`endif

// ===== rtl/ksdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key state double press tracker package
// Command codes and the command and result transfer types.
// ----------------------------------------------------------------------------
package ksdpt_pkg;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  key;
    logic [31:0] now_ms;
    logic [15:0] window_ms;
  } req_t;

  typedef struct packed {
    logic is_pressed;
    logic is_double;
  } rsp_t;

endpackage

// ===== rtl/key_state_double_press_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key state double press tracker
// Per-key entry memory tracking press state and the last two press times.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  command   in         start_i and !busy_o    req_i  (cmd, key, now_ms, window_ms)
//  result    out        done_o, one cycle      rsp_o  (is_pressed, is_double)
//
// One command transfer can be taken in every cycle; busy_o stays low.
// Each command passes the s1 registers and its result then the output registers, in command order.
// The entry memory is read on the transfer and written back in the cycle after it;
// a forwarding register covers a read of the entry being written.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed.
// The receiver cannot stall; done_o and rsp_o are valid for one cycle only.
// ----------------------------------------------------------------------------
module key_state_double_press_tracker_core #(
  parameter int KEY_COUNT = 256,
  parameter int TIME_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ksdpt_pkg::req_t req_i,
  output logic            busy_o,
  output logic            done_o,
  output ksdpt_pkg::rsp_t rsp_o
);
  import ksdpt_pkg::*;

  localparam int Depth = (KEY_COUNT < 256) ? KEY_COUNT : 256;
  localparam int IdxW  = $clog2(Depth);

  typedef struct packed {
    logic                 seen;
    logic                 pressed;
    logic                 prev;
    logic [TIME_BITS-1:0] last_time;
    logic [TIME_BITS-1:0] prev_time;
  } entry_t;

  entry_t               mem_q [Depth];
  logic [Depth-1:0]     written_q;

  logic                 accept;
  logic [IdxW-1:0]      rd_idx;
  logic                 in_range;

  logic                 s1_vld_q;
  logic                 s1_in_q;
  logic [1:0]           s1_cmd_q;
  logic [IdxW-1:0]      s1_idx_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic [15:0]          s1_win_q;
  entry_t               rd_q;
  logic                 rd_ok_q;
  logic                 fwd_hit_q;
  entry_t               fwd_q;

  entry_t               entry_cur;
  entry_t               entry_d;
  logic [TIME_BITS-1:0] age;
  logic                 wr_en;
  rsp_t                 rsp_d;
  rsp_t                 rsp_q;
  logic                 done_q;

  assign busy_o   = 1'b0;
  assign accept   = start_i & ~busy_o;
  assign rd_idx   = req_i.key[IdxW-1:0];
  assign in_range = ({24'd0, req_i.key} < KEY_COUNT);
  assign wr_en    = s1_vld_q & s1_in_q;

  always_comb begin
    entry_cur = rd_q;
    if (fwd_hit_q) begin
      entry_cur = fwd_q;
    end else if (!rd_ok_q) begin
      entry_cur.seen    = 1'b0;
      entry_cur.pressed = 1'b0;
      entry_cur.prev    = 1'b0;
    end

    entry_d = entry_cur;
    case (s1_cmd_q)
      CMD_PRESS: begin
        if (!entry_cur.seen) begin
          entry_d.seen      = 1'b1;
          entry_d.pressed   = 1'b1;
          entry_d.prev      = 1'b0;
          entry_d.last_time = s1_now_q;
        end else if (!entry_cur.pressed) begin
          entry_d.pressed   = 1'b1;
          entry_d.prev      = 1'b1;
          entry_d.prev_time = entry_cur.last_time;
          entry_d.last_time = s1_now_q;
        end
      end
      CMD_RELEASE: begin
        if (entry_cur.seen) begin
          entry_d.pressed = 1'b0;
        end
      end
      default: begin
      end
    endcase

    age              = s1_now_q - entry_d.prev_time;
    rsp_d.is_pressed = s1_in_q & entry_d.seen & entry_d.pressed;
    rsp_d.is_double  = s1_in_q & entry_d.seen & entry_d.prev &
                       (age <= TIME_BITS'(s1_win_q));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_idx_q] <= entry_d;
    end
    if (accept) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      done_q    <= 1'b0;
      written_q <= '0;
      rd_ok_q   <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      done_q   <= s1_vld_q;
      if (wr_en) begin
        written_q[s1_idx_q] <= 1'b1;
      end
      if (accept) begin
        rd_ok_q   <= written_q[rd_idx];
        fwd_hit_q <= wr_en && (s1_idx_q == rd_idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_in_q  <= in_range;
      s1_cmd_q <= req_i.cmd;
      s1_idx_q <= rd_idx;
      s1_now_q <= TIME_BITS'(req_i.now_ms);
      s1_win_q <= req_i.window_ms;
      fwd_q    <= entry_d;
    end
    if (s1_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/ksdpt_sva.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key state double press tracker checker
// Port-level checks on result timing and press state, bound to the core.
// ----------------------------------------------------------------------------
`include "key_state_double_press_tracker_core_defines.svh"

module ksdpt_sva #(
  parameter int KEY_COUNT = 256
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input ksdpt_pkg::req_t req_i,
  input logic            busy_o,
  input logic            done_o,
  input ksdpt_pkg::rsp_t rsp_o
);
  import ksdpt_pkg::*;

  logic xfer;
  logic key_ok;

  assign xfer   = start_i && !busy_o;
  assign key_ok = ({24'd0, req_i.key} < KEY_COUNT);

  `KSDPT_ASSERT_LAT2(a_result_follows, clk_i, rst_ni, xfer, done_o)
  `KSDPT_ASSERT_NOW(a_no_spurious_result, clk_i, rst_ni, done_o, $past(xfer, 2))
  `KSDPT_ASSERT_LAT2(a_press_sets_pressed, clk_i, rst_ni, xfer && key_ok && req_i.cmd == CMD_PRESS, rsp_o.is_pressed)
  `KSDPT_ASSERT_LAT2(a_release_clears, clk_i, rst_ni, xfer && req_i.cmd == CMD_RELEASE, !rsp_o.is_pressed)
  `KSDPT_ASSERT_LAT2(a_out_of_range_zero, clk_i, rst_ni, xfer && !key_ok, !rsp_o.is_pressed && !rsp_o.is_double)

endmodule

bind key_state_double_press_tracker_core ksdpt_sva #(.KEY_COUNT(KEY_COUNT)) u_ksdpt_sva (.*);
